/* hw/rtl/telnet_command_filter_defines.svh */
// assertion macros used by the checker file
`ifndef TELNET_COMMAND_FILTER_DEFINES_SVH
`define TELNET_COMMAND_FILTER_DEFINES_SVH

// property checked only while out of reset
`define TLNF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TLNF_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tlnf_pkg.sv */
package tlnf_pkg;

    localparam int SUB_DEPTH = 64;

    localparam logic [7:0] BYTE_IAC   = 8'd255;
    localparam logic [7:0] BYTE_DONT  = 8'd254;
    localparam logic [7:0] BYTE_DO    = 8'd253;
    localparam logic [7:0] BYTE_WONT  = 8'd252;
    localparam logic [7:0] BYTE_WILL  = 8'd251;
    localparam logic [7:0] BYTE_SB    = 8'd250;
    localparam logic [7:0] BYTE_SE    = 8'd240;
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_NAWS   = 8'd31;

    // naws report length and the index width of its buffer
    localparam int NAWS_LEN = 5;
    localparam int NAWS_AW  = 3;

    localparam logic [15:0] COLS_RESET = 16'd80;
    localparam logic [15:0] ROWS_RESET = 16'd25;

    // classified operation codes
    localparam logic [3:0] OP_PASS   = 4'd0;
    localparam logic [3:0] OP_NONE   = 4'd1;
    localparam logic [3:0] OP_PLAIN  = 4'd2;
    localparam logic [3:0] OP_SB     = 4'd3;
    localparam logic [3:0] OP_SE     = 4'd4;
    localparam logic [3:0] OP_DONT   = 4'd5;
    localparam logic [3:0] OP_DO     = 4'd6;
    localparam logic [3:0] OP_WONT   = 4'd7;
    localparam logic [3:0] OP_WILL   = 4'd8;
    localparam logic [3:0] OP_BINARY = 4'd9;

    // queue between front and back
    localparam int Q_AW = 1;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] rx_byte;
    } t_op;

endpackage

/* hw/rtl/tlnf_front.sv */
module tlnf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enable,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_full,
    output logic          o_push,
    output tlnf_pkg::t_op o_op
);

    logic r_iac_seen;
    logic n_iac_seen;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        n_iac_seen     = r_iac_seen;
        o_op.rx_byte   = i_byte;
        o_op.op        = tlnf_pkg::OP_NONE;
        if (!i_enable) begin
            o_op.op = tlnf_pkg::OP_PASS;
        end else if (i_byte == tlnf_pkg::BYTE_IAC && !r_iac_seen) begin
            n_iac_seen = 1'b1;
        end else if (r_iac_seen && i_byte != tlnf_pkg::BYTE_IAC) begin
            n_iac_seen = 1'b0;
            case (i_byte)
                tlnf_pkg::BYTE_SB:    o_op.op = tlnf_pkg::OP_SB;
                tlnf_pkg::BYTE_SE:    o_op.op = tlnf_pkg::OP_SE;
                tlnf_pkg::BYTE_DONT:  o_op.op = tlnf_pkg::OP_DONT;
                tlnf_pkg::BYTE_DO:    o_op.op = tlnf_pkg::OP_DO;
                tlnf_pkg::BYTE_WONT:  o_op.op = tlnf_pkg::OP_WONT;
                tlnf_pkg::BYTE_WILL:  o_op.op = tlnf_pkg::OP_WILL;
                tlnf_pkg::OPT_BINARY: o_op.op = tlnf_pkg::OP_BINARY;
                default:              o_op.op = tlnf_pkg::OP_NONE;
            endcase
        end else begin
            // plain byte or second iac of a pair
            n_iac_seen = 1'b0;
            o_op.op    = tlnf_pkg::OP_PLAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iac_seen <= 1'b0;
        end else if (o_push) begin
            r_iac_seen <= n_iac_seen;
        end
    end

endmodule

/* hw/rtl/tlnf_fifo.sv */
module tlnf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tlnf_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output tlnf_pkg::t_op o_op
);

    localparam int DEPTH = 2 ** tlnf_pkg::Q_AW;

    tlnf_pkg::t_op                r_mem [DEPTH];
    logic [tlnf_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [tlnf_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [tlnf_pkg::Q_AW:0]      r_count;

    assign o_full     = (r_count == (tlnf_pkg::Q_AW+1)'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_op       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/tlnf_back.sv */
module tlnf_back #(
    parameter int SUB_DEPTH = tlnf_pkg::SUB_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_nonempty,
    input  tlnf_pkg::t_op i_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_data_valid,
    output logic [7:0]    o_data_byte,
    output logic          o_overflow_error,
    output logic          o_size_update,
    output logic [15:0]   o_window_cols,
    output logic [15:0]   o_window_rows,
    output logic          o_binary_mode
);

    localparam int CNT_W = $clog2(SUB_DEPTH + 1);

    logic             r_in_subneg, n_in_subneg;
    logic             r_pend_do, n_pend_do;
    logic             r_pend_dont, n_pend_dont;
    logic             r_pend_will, n_pend_will;
    logic             r_pend_wont, n_pend_wont;
    logic             r_binary, n_binary;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_cols, n_cols;
    logic [15:0]      r_rows, n_rows;
    logic [7:0]       r_sub_bytes [tlnf_pkg::NAWS_LEN];
    logic             n_store;

    logic             r_valid;
    logic             r_data_valid, n_data_valid;
    logic [7:0]       r_data_byte;
    logic             r_ovf, n_ovf;
    logic             r_upd, n_upd;

    logic [15:0]      w_width;
    logic [15:0]      w_height;

    assign o_pop    = i_nonempty && (!r_valid || i_ready);
    assign w_width  = {r_sub_bytes[1], r_sub_bytes[2]};
    assign w_height = {r_sub_bytes[3], r_sub_bytes[4]};

    always_comb begin
        n_in_subneg  = r_in_subneg;
        n_pend_do    = r_pend_do;
        n_pend_dont  = r_pend_dont;
        n_pend_will  = r_pend_will;
        n_pend_wont  = r_pend_wont;
        n_binary     = r_binary;
        n_count      = r_count;
        n_cols       = r_cols;
        n_rows       = r_rows;
        n_store      = 1'b0;
        n_data_valid = 1'b0;
        n_ovf        = 1'b0;
        n_upd        = 1'b0;
        case (i_op.op)
            tlnf_pkg::OP_PASS: begin
                n_data_valid = 1'b1;
            end
            tlnf_pkg::OP_SB: begin
                n_count     = '0;
                n_in_subneg = 1'b1;
            end
            tlnf_pkg::OP_SE: begin
                if (r_in_subneg) begin
                    if (r_count >= CNT_W'(tlnf_pkg::NAWS_LEN)
                        && r_sub_bytes[0] == tlnf_pkg::OPT_NAWS) begin
                        if (w_width != '0) begin
                            n_cols = w_width;
                        end
                        if (w_height != '0) begin
                            n_rows = w_height;
                        end
                        n_upd = 1'b1;
                    end
                    n_count     = '0;
                    n_in_subneg = 1'b0;
                end
            end
            tlnf_pkg::OP_DONT:   n_pend_dont = 1'b1;
            tlnf_pkg::OP_DO:     n_pend_do   = 1'b1;
            tlnf_pkg::OP_WONT:   n_pend_wont = 1'b1;
            tlnf_pkg::OP_WILL:   n_pend_will = 1'b1;
            tlnf_pkg::OP_BINARY: n_binary    = r_pend_do;
            tlnf_pkg::OP_PLAIN: begin
                if (r_in_subneg) begin
                    if (r_count >= CNT_W'(SUB_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_store = (r_count < CNT_W'(tlnf_pkg::NAWS_LEN));
                        n_count = r_count + 1'b1;
                    end
                end else if (r_pend_dont) begin
                    n_pend_dont = 1'b0;
                end else if (r_pend_do) begin
                    n_pend_do = 1'b0;
                end else if (r_pend_wont) begin
                    n_pend_wont = 1'b0;
                end else if (r_pend_will) begin
                    n_pend_will = 1'b0;
                end else begin
                    n_data_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_store) begin
            r_sub_bytes[r_count[tlnf_pkg::NAWS_AW-1:0]] <= i_op.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_subneg <= 1'b0;
            r_pend_do   <= 1'b0;
            r_pend_dont <= 1'b0;
            r_pend_will <= 1'b0;
            r_pend_wont <= 1'b0;
            r_binary    <= 1'b0;
            r_count     <= '0;
            r_cols      <= tlnf_pkg::COLS_RESET;
            r_rows      <= tlnf_pkg::ROWS_RESET;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_subneg <= n_in_subneg;
                r_pend_do   <= n_pend_do;
                r_pend_dont <= n_pend_dont;
                r_pend_will <= n_pend_will;
                r_pend_wont <= n_pend_wont;
                r_binary    <= n_binary;
                r_count     <= n_count;
                r_cols      <= n_cols;
                r_rows      <= n_rows;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data_valid <= n_data_valid;
            r_data_byte  <= n_data_valid ? i_op.rx_byte : 8'd0;
            r_ovf        <= n_ovf;
            r_upd        <= n_upd;
        end
    end

    assign o_valid          = r_valid;
    assign o_data_valid     = r_data_valid;
    assign o_data_byte      = r_data_byte;
    assign o_overflow_error = r_ovf;
    assign o_size_update    = r_upd;
    assign o_window_cols    = r_cols;
    assign o_window_rows    = r_rows;
    assign o_binary_mode    = r_binary;

endmodule

/* hw/rtl/telnet_command_filter.sv */
// channel  | handshake                    | payload
// ---------+------------------------------+--------------------------------------------
// rx       | i_rx_valid / o_rx_ready      | i_rx_byte
// result   | o_res_valid / i_res_ready    | o_res_data_valid .. o_res_binary_mode
// cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_telnet_enable
//
// one byte per cycle sustained while results are taken; a byte that is taken is written to
// the queue, then the back end registers its result, which can be taken at the next edge
// the two-entry queue and the result register let rx keep flowing while a result waits
// reset is synchronous, active low; it restores 80x25, clears the option, mode and valid flags, enables filtering
// rx stalls only when the queue is full, i.e. the result side has held off while both entries filled
module telnet_command_filter #(
    parameter int SUB_DEPTH = tlnf_pkg::SUB_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input transactions
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result transactions
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_res_data_valid,
    output logic [7:0]  o_res_data_byte,
    output logic        o_res_overflow_error,
    output logic        o_res_size_update,
    output logic [15:0] o_res_window_cols,
    output logic [15:0] o_res_window_rows,
    output logic        o_res_binary_mode,
    // configuration write transactions
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_telnet_enable
);

    // enable register; the user must write it only while the block is idle, the block does not enforce this
    logic r_telnet_enable;

    // front to queue
    logic          w_push;
    logic          w_full;
    tlnf_pkg::t_op w_front_op;

    // queue to back
    logic          w_pop;
    logic          w_nonempty;
    tlnf_pkg::t_op w_back_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_telnet_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_telnet_enable <= i_cfg_telnet_enable;
        end
    end

    // front: tracks the iac prefix and classifies each byte into an operation
    tlnf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_telnet_enable),
        .i_valid  (i_rx_valid),
        .o_ready  (o_rx_ready),
        .i_byte   (i_rx_byte),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_op     (w_front_op)
    );

    // short queue decoupling the two halves
    tlnf_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_op       (w_front_op),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_op       (w_back_op)
    );

    // back: option flags, subnegotiation buffer, naws decode, result register
    tlnf_back #(
        .SUB_DEPTH (SUB_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_nonempty       (w_nonempty),
        .i_op             (w_back_op),
        .o_pop            (w_pop),
        .o_valid          (o_res_valid),
        .i_ready          (i_res_ready),
        .o_data_valid     (o_res_data_valid),
        .o_data_byte      (o_res_data_byte),
        .o_overflow_error (o_res_overflow_error),
        .o_size_update    (o_res_size_update),
        .o_window_cols    (o_res_window_cols),
        .o_window_rows    (o_res_window_rows),
        .o_binary_mode    (o_res_binary_mode)
    );

endmodule

/* hw/rtl/tlnf_checker.sv */
`include "telnet_command_filter_defines.svh"

module tlnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic        o_res_data_valid,
    input logic [7:0]  o_res_data_byte,
    input logic        o_res_overflow_error,
    input logic        o_res_size_update,
    input logic [15:0] o_res_window_cols,
    input logic [15:0] o_res_window_rows
);

    // a waiting result holds until taken
    `TLNF_ASSERT(a_res_hold, i_clk, i_rst_n,
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res_data_byte),
        "result dropped or changed while stalled")

    // reset empties the result register
    `TLNF_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_res_valid,
        "result valid right after reset")

    // data bytes never carry error or size flags
    `TLNF_ASSERT(a_data_excl, i_clk, i_rst_n,
        o_res_valid && o_res_data_valid |-> !o_res_overflow_error && !o_res_size_update,
        "data byte flagged as telnet traffic")

    // consumed bytes read back as zero
    `TLNF_ASSERT(a_consumed_zero, i_clk, i_rst_n,
        o_res_valid && !o_res_data_valid |-> o_res_data_byte == 8'd0,
        "consumed byte not zeroed")

    // window size never becomes zero
    `TLNF_ASSERT(a_size_nonzero, i_clk, i_rst_n,
        o_res_valid |-> o_res_window_cols != 16'd0 && o_res_window_rows != 16'd0,
        "window size went to zero")

endmodule

bind telnet_command_filter tlnf_checker u_tlnf_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_res_valid          (o_res_valid),
    .i_res_ready          (i_res_ready),
    .o_res_data_valid     (o_res_data_valid),
    .o_res_data_byte      (o_res_data_byte),
    .o_res_overflow_error (o_res_overflow_error),
    .o_res_size_update    (o_res_size_update),
    .o_res_window_cols    (o_res_window_cols),
    .o_res_window_rows    (o_res_window_rows)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

// one result transaction as the block presents it
typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        overflow_error;
    logic        size_update;
    logic [15:0] window_cols;
    logic [15:0] window_rows;
    logic        binary_mode;
} t_filter_result;

// shadow copy of the filter state, predicts one result per accepted byte
class telnet_filter_tracker;
    bit          enable;
    bit          iac_seen;
    bit          in_sub;
    bit          pend_do;
    bit          pend_dont;
    bit          pend_will;
    bit          pend_wont;
    bit          binary;
    logic [7:0]  sub_buf [tlnf_pkg::NAWS_LEN];
    int unsigned sub_cnt;
    logic [15:0] cols;
    logic [15:0] rows;

    t_filter_result awaited_results [$];

    int errors;
    int n_bytes;
    int n_data;
    int n_updates;
    int n_overflow;

    function new();
        enable = 1'b1;
        cols   = tlnf_pkg::COLS_RESET;
        rows   = tlnf_pkg::ROWS_RESET;
        foreach (sub_buf[i]) sub_buf[i] = 8'h00;
    endfunction

    function void take_byte(logic [7:0] b);
        t_filter_result r;
        logic [15:0] w;
        logic [15:0] h;
        r = '0;
        if (!enable) begin
            r.data_valid = 1'b1;
        end else if (b == tlnf_pkg::BYTE_IAC && !iac_seen) begin
            iac_seen = 1'b1;
        end else if (iac_seen && b != tlnf_pkg::BYTE_IAC) begin
            iac_seen = 1'b0;
            case (b)
                tlnf_pkg::BYTE_SB: begin
                    sub_cnt = 0;
                    in_sub  = 1'b1;
                end
                tlnf_pkg::BYTE_SE: begin
                    if (in_sub) begin
                        if (sub_cnt >= tlnf_pkg::NAWS_LEN
                            && sub_buf[0] == tlnf_pkg::OPT_NAWS) begin
                            w = {sub_buf[1], sub_buf[2]};
                            h = {sub_buf[3], sub_buf[4]};
                            if (w != 16'd0) cols = w;
                            if (h != 16'd0) rows = h;
                            r.size_update = 1'b1;
                        end
                        sub_cnt = 0;
                        in_sub  = 1'b0;
                    end
                end
                tlnf_pkg::BYTE_DONT:  pend_dont = 1'b1;
                tlnf_pkg::BYTE_DO:    pend_do   = 1'b1;
                tlnf_pkg::BYTE_WONT:  pend_wont = 1'b1;
                tlnf_pkg::BYTE_WILL:  pend_will = 1'b1;
                tlnf_pkg::OPT_BINARY: binary    = pend_do;
                default: ;
            endcase
        end else begin
            iac_seen = 1'b0;
            if (in_sub) begin
                if (sub_cnt >= tlnf_pkg::SUB_DEPTH) begin
                    r.overflow_error = 1'b1;
                end else begin
                    if (sub_cnt < tlnf_pkg::NAWS_LEN) sub_buf[sub_cnt] = b;
                    sub_cnt++;
                end
            end else if (pend_dont) begin
                pend_dont = 1'b0;
            end else if (pend_do) begin
                pend_do = 1'b0;
            end else if (pend_wont) begin
                pend_wont = 1'b0;
            end else if (pend_will) begin
                pend_will = 1'b0;
            end else begin
                r.data_valid = 1'b1;
            end
        end
        if (r.data_valid) r.data_byte = b;
        r.window_cols = cols;
        r.window_rows = rows;
        r.binary_mode = binary;
        n_bytes++;
        n_data     += r.data_valid;
        n_updates  += r.size_update;
        n_overflow += r.overflow_error;
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void match_result(t_filter_result got);
        t_filter_result want;
        if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: result with no byte outstanding, expected none, actual %h",
                     $time, got);
            return;
        end
        want = awaited_results.pop_front();
        check_field("data_valid", 16'(want.data_valid), 16'(got.data_valid));
        check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        check_field("overflow_error", 16'(want.overflow_error), 16'(got.overflow_error));
        check_field("size_update", 16'(want.size_update), 16'(got.size_update));
        check_field("window_cols", want.window_cols, got.window_cols);
        check_field("window_rows", want.window_rows, got.window_rows);
        check_field("binary_mode", 16'(want.binary_mode), 16'(got.binary_mode));
    endfunction
endclass

module testbench;

    // cycles with no transaction on any channel before the run is called hung
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic        o_res_data_valid;
    logic [7:0]  o_res_data_byte;
    logic        o_res_overflow_error;
    logic        o_res_size_update;
    logic [15:0] o_res_window_cols;
    logic [15:0] o_res_window_rows;
    logic        o_res_binary_mode;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_telnet_enable = 1'b1;

    telnet_filter_tracker tracker = new();

    int bytes_sent;
    int res_count;
    int res_seen;
    int res_hold;
    int quiet_cycles;
    int settings_run;
    bit rx_quiet;
    bit res_quiet;

    telnet_command_filter DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_res_data_valid    (o_res_data_valid),
        .o_res_data_byte     (o_res_data_byte),
        .o_res_overflow_error(o_res_overflow_error),
        .o_res_size_update   (o_res_size_update),
        .o_res_window_cols   (o_res_window_cols),
        .o_res_window_rows   (o_res_window_rows),
        .o_res_binary_mode   (o_res_binary_mode),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_telnet_enable (i_cfg_telnet_enable)
    );

    always #5 i_clk = ~i_clk;

    // all transactions are observed here, in one place, so the order of
    // config, byte and result handling within an edge is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tracker.enable = i_cfg_telnet_enable;
            // note the byte before checking, so even a result in the same cycle as its byte lines up
            if (i_rx_valid && o_rx_ready) tracker.take_byte(i_rx_byte);
            if (o_res_valid && i_res_ready) begin
                tracker.match_result({o_res_data_valid, o_res_data_byte,
                                      o_res_overflow_error, o_res_size_update,
                                      o_res_window_cols, o_res_window_rows,
                                      o_res_binary_mode});
                res_count++;
            end
            // watchdog: any transaction restarts the count
            if ((i_cfg_valid && o_cfg_ready) || (i_rx_valid && o_rx_ready) ||
                (o_res_valid && i_res_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("telnet_command_filter regression: fail");
                $finish;
            end
        end
    end

    // result side back-pressure: after each taken result draw a fresh hold-off,
    // with occasional stretches of 64 results taken back to back
    always @(negedge i_clk) begin
        if (res_count != res_seen) begin
            res_seen = res_count;
            if (res_seen % 64 == 0) res_quiet = ($urandom_range(0, 3) == 0);
            res_hold = res_quiet ? 0 : $urandom_range(0, 10);
        end
        if (res_hold > 0) begin
            i_res_ready <= 1'b0;
            res_hold--;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // one byte transaction with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bytes_sent % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        gap = rx_quiet ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
    endtask

    // a byte inside a subnegotiation; a literal 255 has to be doubled
    task automatic send_sub_byte(input logic [7:0] b);
        send_byte(b);
        if (b == tlnf_pkg::BYTE_IAC) send_byte(tlnf_pkg::BYTE_IAC);
    endtask

    // config writes only once the block has drained
    task automatic write_enable(input logic v);
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_telnet_enable <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // drop valid, wait for every outstanding result, then let the block idle
    task automatic settle();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_verb();
        case ($urandom_range(0, 3))
            0:       return tlnf_pkg::BYTE_DO;
            1:       return tlnf_pkg::BYTE_DONT;
            2:       return tlnf_pkg::BYTE_WILL;
            default: return tlnf_pkg::BYTE_WONT;
        endcase
    endfunction

    // window dimension: zero (keep old value), small, all ones, or anything
    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 300));
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed naws report, sometimes with trailing bytes
    task automatic send_window_report();
        logic [15:0] w;
        logic [15:0] h;
        w = pick_size();
        h = pick_size();
        send_byte(tlnf_pkg::BYTE_IAC);
        send_byte(tlnf_pkg::BYTE_SB);
        send_sub_byte(tlnf_pkg::OPT_NAWS);
        send_sub_byte(w[15:8]);
        send_sub_byte(w[7:0]);
        send_sub_byte(h[15:8]);
        send_sub_byte(h[7:0]);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_sub_byte(8'($urandom));
        send_byte(tlnf_pkg::BYTE_IAC);
        send_byte(tlnf_pkg::BYTE_SE);
    endtask

    // opening sequence: byte extremes, literal 255, stray SE, stacked pending
    // flags, binary after DO, restart of SB and a report with a zero height
    task automatic send_opening();
        logic [7:0] seq [$];
        seq = '{8'h00, 8'h80,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_IAC,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_SE,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_DONT,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_DO,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::OPT_BINARY,
                8'h05, 8'h06,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_SB, tlnf_pkg::OPT_NAWS,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_SB, tlnf_pkg::OPT_NAWS,
                8'h01, 8'h00, 8'h00, 8'h00,
                tlnf_pkg::BYTE_IAC, tlnf_pkg::BYTE_SE};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // one randomly chosen stretch of traffic, mostly well-formed protocol
    task automatic send_sequence();
        int         kind;
        int         n;
        logic [7:0] first;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // plain data, a random 255 opens a command now and then
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (kind < 38) begin
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_IAC);
        end else if (kind < 53) begin
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(pick_verb());
            send_byte(8'($urandom));
        end else if (kind < 59) begin
            // binary rule, with or without a verb pending
            if ($urandom_range(0, 1)) begin
                send_byte(tlnf_pkg::BYTE_IAC);
                send_byte(pick_verb());
            end
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::OPT_BINARY);
            if ($urandom_range(0, 1)) send_byte(8'($urandom));
        end else if (kind < 75) begin
            send_window_report();
        end else if (kind < 82) begin
            // short report or foreign option
            n     = $urandom_range(0, 8);
            first = $urandom_range(0, 1) ? tlnf_pkg::OPT_NAWS : 8'($urandom);
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_SB);
            if (n > 0) begin
                send_sub_byte(first);
                repeat (n - 1) send_sub_byte(8'($urandom));
            end
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_SE);
        end else if (kind < 84) begin
            // long subnegotiation around the buffer depth, usually overflowing
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_SB);
            send_sub_byte($urandom_range(0, 3) != 0 ? tlnf_pkg::OPT_NAWS : 8'($urandom));
            repeat (tlnf_pkg::SUB_DEPTH - 2 + $urandom_range(0, 8))
                send_sub_byte(8'($urandom));
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_SE);
        end else if (kind < 90) begin
            // broken sequences
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(tlnf_pkg::BYTE_IAC);
                    send_byte(tlnf_pkg::BYTE_SE);
                end
                1: begin
                    send_byte(tlnf_pkg::BYTE_IAC);
                    send_byte(tlnf_pkg::BYTE_SB);
                    repeat ($urandom_range(0, 3)) send_sub_byte(8'($urandom));
                end
                2: begin
                    send_byte(tlnf_pkg::BYTE_IAC);
                    send_byte(8'($urandom));
                end
                default: begin
                    // pending verb carried through a report
                    send_byte(tlnf_pkg::BYTE_IAC);
                    send_byte(pick_verb());
                    send_window_report();
                end
            endcase
        end else begin
            // SB inside SB restarts the buffer
            send_byte(tlnf_pkg::BYTE_IAC);
            send_byte(tlnf_pkg::BYTE_SB);
            repeat ($urandom_range(0, 3)) send_sub_byte(8'($urandom));
            send_window_report();
        end
    endtask

    task automatic send_random_traffic(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) send_sequence();
    endtask

    initial begin
        bit phase_enable [5];
        int phase_len    [5];
        phase_enable = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_len    = '{550, 150, 400, 50, 200};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_enable(1'b1);
        send_opening();
        settle();

        // filtering on and off in turn, state carried across the switches
        foreach (phase_enable[p]) begin
            write_enable(phase_enable[p]);
            send_random_traffic(phase_len[p]);
            settle();
        end

        $display("covered %0d bytes over %0d enable writes: %0d passed as data",
                 tracker.n_bytes, settings_run, tracker.n_data);
        $display("%0d window reports, %0d overflowing subnegotiation bytes",
                 tracker.n_updates, tracker.n_overflow);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
            $display("telnet_command_filter regression: pass");
        end else begin
            $display("telnet_command_filter regression: fail");
        end
        $finish;
    end

endmodule
